// ----- src/tshr_pkg.sv -----
// Shared types, constants and a helper function of the timed sweep, hold and return controller.
package tshr_pkg;

    // Widths
    localparam int TIME_BITS     = 24;
    localparam int DUTY_BITS     = 10;
    localparam int ANG_BITS      = 10;
    localparam int PCT_BITS      = 7;
    localparam int OP_BITS       = 2;
    localparam int REPLY_BITS    = 2;
    localparam int PHASE_BITS    = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = TIME_BITS;
    localparam int PROD_BITS     = ANG_BITS + TIME_BITS;
    localparam int CNT_BITS      = $clog2(ANG_BITS);

    // Saturation limit of the elapsed counters
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Duty scaling: full scale times percent over one hundred, by reciprocal
    localparam logic [PCT_BITS-1:0] PCT_FULL    = PCT_BITS'(100);
    localparam int                  RECIP_SHIFT = 24;
    localparam longint              RECIP       = ((longint'(1) << RECIP_SHIFT) + 99) / 100;
    localparam int                  RECIP_BITS  = $clog2(RECIP + 1);
    localparam longint              DUTY_MAX    = (longint'(1) << DUTY_BITS) - 1;
    localparam longint              DUTY_COEF   = DUTY_MAX * RECIP;
    localparam int                  DUTY_PROD_BITS = PCT_BITS + DUTY_BITS + RECIP_BITS;

    // Register reset values
    localparam logic [TIME_BITS-1:0]       RST_FULL_SWEEP = TIME_BITS'(9375);
    localparam logic signed [ANG_BITS-1:0] RST_HOME       = ANG_BITS'(0);
    localparam logic signed [ANG_BITS-1:0] RST_TARGET     = ANG_BITS'(90);
    localparam logic [TIME_BITS-1:0]       RST_DEF_HOLD   = TIME_BITS'(5000);
    localparam logic [PCT_BITS-1:0]        RST_DUTY       = PCT_BITS'(100);
    localparam logic                       RST_FWD_HIGH   = 1'b1;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE = 2'd0,
        PH_OUT  = 2'd1,
        PH_HOLD = 2'd2,
        PH_BACK = 2'd3
    } t_phase;

    typedef enum logic [OP_BITS-1:0] {
        OP_TICK     = 2'd0,
        OP_ROTATE   = 2'd1,
        OP_ZERO     = 2'd2,
        OP_SET_HOLD = 2'd3
    } t_op;

    typedef enum logic [REPLY_BITS-1:0] {
        RP_OK        = 2'd0,
        RP_BUSY      = 2'd1,
        RP_HOLD_ZERO = 2'd2
    } t_reply;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FULL_SWEEP = 3'd0,
        CFG_HOME       = 3'd1,
        CFG_TARGET     = 3'd2,
        CFG_DEF_HOLD   = 3'd3,
        CFG_DUTY       = 3'd4,
        CFG_FWD_HIGH   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_INIT,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_BITS-1:0]       full_sweep_ms;
        logic signed [ANG_BITS-1:0] home_angle;
        logic signed [ANG_BITS-1:0] target_angle;
        logic [TIME_BITS-1:0]       default_hold_ms;
        logic [PCT_BITS-1:0]        duty_percent;
        logic                       forward_is_high;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_init;
        logic div_step;
        logic publish;
    } t_cmd;

    // Scale a percentage (at most one hundred) to the PWM full scale, rounding down
    function automatic logic [DUTY_BITS-1:0] duty_scale(input logic [PCT_BITS-1:0] pct);
        logic [DUTY_PROD_BITS-1:0] prod;
        prod = DUTY_PROD_BITS'(pct) * DUTY_PROD_BITS'(DUTY_COEF);
        return prod[RECIP_SHIFT +: DUTY_BITS];
    endfunction

endpackage

// ----- src/tshr_if.sv -----
// Handshake channel interfaces for command beats in and status beats out.
interface tshr_in_if;
    import tshr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_BITS-1:0]   opcode;
    logic [TIME_BITS-1:0] hold_value_ms;

    modport source (output valid, output opcode, output hold_value_ms, input ready);
    modport sink (input valid, input opcode, input hold_value_ms, output ready);
endinterface

interface tshr_out_if;
    import tshr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REPLY_BITS-1:0]      reply_code;
    logic [PHASE_BITS-1:0]      phase;
    logic signed [ANG_BITS-1:0] estimated_angle;
    logic [TIME_BITS-1:0]       remaining_hold_ms;
    logic                       direction_level;
    logic [DUTY_BITS-1:0]       pwm_duty;

    modport source (
        output valid, output reply_code, output phase, output estimated_angle,
        output remaining_hold_ms, output direction_level, output pwm_duty,
        input ready
    );
    modport sink (
        input valid, input reply_code, input phase, input estimated_angle,
        input remaining_hold_ms, input direction_level, input pwm_duty,
        output ready
    );
endinterface

// ----- src/tshr_cfg.sv -----
// Configuration register file written through the plain write port.
module tshr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tshr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tshr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output tshr_pkg::t_cfg                      o_cfg
);
    import tshr_pkg::*;

    t_cfg r_cfg, n_cfg;

    // Decode the write into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FULL_SWEEP: n_cfg.full_sweep_ms   = i_cfg_data[TIME_BITS-1:0];
                CFG_HOME:       n_cfg.home_angle      = i_cfg_data[ANG_BITS-1:0];
                CFG_TARGET:     n_cfg.target_angle    = i_cfg_data[ANG_BITS-1:0];
                CFG_DEF_HOLD:   n_cfg.default_hold_ms = i_cfg_data[TIME_BITS-1:0];
                CFG_DUTY:       n_cfg.duty_percent    = i_cfg_data[PCT_BITS-1:0];
                CFG_FWD_HIGH:   n_cfg.forward_is_high = i_cfg_data[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_sweep_ms   <= RST_FULL_SWEEP;
            r_cfg.home_angle      <= RST_HOME;
            r_cfg.target_angle    <= RST_TARGET;
            r_cfg.default_hold_ms <= RST_DEF_HOLD;
            r_cfg.duty_percent    <= RST_DUTY;
            r_cfg.forward_is_high <= RST_FWD_HIGH;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/tshr_ctrl.sv -----
// Sequencer: accepts a beat, steps the multiply and divide, loads the output register.
module tshr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_ready,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output tshr_pkg::t_cmd o_cmd
);
    import tshr_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ANG_BITS - 1);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                w_accept;
    logic                w_publish;

    assign w_accept  = (r_state == ST_IDLE) && i_in_valid;
    assign w_publish = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_INIT;
            ST_INIT: n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CNT_LAST) n_state = ST_DONE;
            ST_DONE: if (w_publish) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Count divide steps, clear outside the divide
    always_comb begin
        n_cnt = '0;
        if (r_state == ST_DIV && r_cnt != CNT_LAST) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    // Hold the output beat until taken
    always_comb begin
        if (w_publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept;
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.div_init = (r_state == ST_INIT);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.publish  = w_publish;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DIV) |-> (r_cnt == '0))
        else $error("divide step counter not cleared outside divide");

    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MUL))
        else $error("accepted beat did not start the multiply");

    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("output beat raised outside the done state");

endmodule

// ----- src/tshr_dp.sv -----
// Datapath: arm phase state, interpolation multiply, restoring divider and output register.
module tshr_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tshr_pkg::t_cmd                         i_cmd,
    input  tshr_pkg::t_cfg                         i_cfg,
    input  logic [tshr_pkg::OP_BITS-1:0]           i_opcode,
    input  logic [tshr_pkg::TIME_BITS-1:0]         i_hold_value_ms,
    output logic [tshr_pkg::REPLY_BITS-1:0]        o_reply_code,
    output logic [tshr_pkg::PHASE_BITS-1:0]        o_phase,
    output logic signed [tshr_pkg::ANG_BITS-1:0]   o_estimated_angle,
    output logic [tshr_pkg::TIME_BITS-1:0]         o_remaining_hold_ms,
    output logic                                   o_direction_level,
    output logic [tshr_pkg::DUTY_BITS-1:0]         o_pwm_duty
);
    import tshr_pkg::*;

    // Arm state
    t_phase                     r_phase, n_phase;
    logic [TIME_BITS-1:0]       r_move_el, n_move_el;
    logic [TIME_BITS-1:0]       r_move_dur, n_move_dur;
    logic [TIME_BITS-1:0]       r_hold_el, n_hold_el;
    logic [TIME_BITS-1:0]       r_hold_len, n_hold_len;
    logic signed [ANG_BITS-1:0] r_angle, n_angle;
    logic                       r_dir, n_dir;
    logic                       r_run, n_run;
    t_reply                     r_reply, n_reply;

    // Interpolation
    logic [PROD_BITS-1:0]       r_prod;
    logic                       r_neg;
    logic [TIME_BITS-1:0]       r_rem;
    logic [ANG_BITS-1:0]        r_quo;

    // Output register
    logic [REPLY_BITS-1:0]      r_o_reply;
    logic [PHASE_BITS-1:0]      r_o_phase;
    logic signed [ANG_BITS-1:0] r_o_angle;
    logic [TIME_BITS-1:0]       r_o_remain;
    logic                       r_o_dir;
    logic [DUTY_BITS-1:0]       r_o_duty;

    t_op                        w_op;
    logic [TIME_BITS-1:0]       w_el_inc;
    logic [TIME_BITS-1:0]       w_hel_inc;
    logic [TIME_BITS-1:0]       w_el_min;
    logic                       w_moving;
    logic signed [ANG_BITS-1:0] w_from;
    logic signed [ANG_BITS-1:0] w_to;
    logic signed [ANG_BITS:0]   w_from_x;
    logic signed [ANG_BITS:0]   w_to_x;
    logic signed [ANG_BITS:0]   w_diff;
    logic                       w_neg;
    logic [ANG_BITS-1:0]        w_mag;
    logic [TIME_BITS:0]         w_trial;
    logic                       w_ge;
    logic signed [ANG_BITS:0]   w_q_s;
    logic signed [ANG_BITS:0]   w_sum;
    logic signed [ANG_BITS-1:0] w_interp;
    logic [PCT_BITS-1:0]        w_pct;
    logic [TIME_BITS-1:0]       w_remain;

    assign w_op      = t_op'(i_opcode);
    assign w_el_inc  = (r_move_el == TIME_MAX) ? TIME_MAX : r_move_el + 1'b1;
    assign w_hel_inc = (r_hold_el == TIME_MAX) ? TIME_MAX : r_hold_el + 1'b1;
    assign w_el_min  = (r_move_el < r_move_dur) ? r_move_el : r_move_dur;
    assign w_moving  = (r_phase == PH_OUT) || (r_phase == PH_BACK);

    // Sweep end points follow the direction of travel
    assign w_from   = (r_phase == PH_BACK) ? i_cfg.target_angle : i_cfg.home_angle;
    assign w_to     = (r_phase == PH_BACK) ? i_cfg.home_angle : i_cfg.target_angle;
    assign w_from_x = {w_from[ANG_BITS-1], w_from};
    assign w_to_x   = {w_to[ANG_BITS-1], w_to};
    assign w_diff   = w_to_x - w_from_x;
    assign w_neg    = w_diff[ANG_BITS];
    assign w_mag    = w_neg ? ANG_BITS'(-w_diff) : ANG_BITS'(w_diff);

    // One restoring divide step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[ANG_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_move_dur});

    // Signed quotient truncates toward zero, then offset from the start point
    assign w_q_s  = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_sum  = w_from_x + w_q_s;
    assign w_interp = (r_move_dur == '0) ? w_to : w_sum[ANG_BITS-1:0];

    assign w_pct    = (i_cfg.duty_percent > PCT_FULL) ? PCT_FULL : i_cfg.duty_percent;
    assign w_remain = (r_phase == PH_HOLD && r_hold_el < r_hold_len) ?
                      r_hold_len - r_hold_el : '0;

    // Apply the command beat to the arm state
    always_comb begin
        n_phase    = r_phase;
        n_move_el  = r_move_el;
        n_move_dur = r_move_dur;
        n_hold_el  = r_hold_el;
        n_hold_len = r_hold_len;
        n_angle    = r_angle;
        n_dir      = r_dir;
        n_run      = r_run;
        n_reply    = r_reply;
        if (i_cmd.load) begin
            n_reply = RP_OK;
            unique case (w_op)
                OP_TICK: begin
                    unique case (r_phase)
                        PH_OUT: begin
                            n_move_el = w_el_inc;
                            if (w_el_inc >= r_move_dur) begin
                                n_angle   = i_cfg.target_angle;
                                n_run     = 1'b0;
                                n_phase   = PH_HOLD;
                                n_hold_el = '0;
                            end
                        end
                        PH_HOLD: begin
                            n_hold_el = w_hel_inc;
                            if (w_hel_inc >= r_hold_len) begin
                                n_move_dur = i_cfg.full_sweep_ms;
                                n_move_el  = '0;
                                n_phase    = PH_BACK;
                                n_dir      = !i_cfg.forward_is_high;
                                n_run      = 1'b1;
                            end
                        end
                        PH_BACK: begin
                            n_move_el = w_el_inc;
                            if (w_el_inc >= r_move_dur) begin
                                n_angle    = i_cfg.home_angle;
                                n_run      = 1'b0;
                                n_phase    = PH_IDLE;
                                n_hold_len = i_cfg.default_hold_ms;
                            end
                        end
                        PH_IDLE: begin
                            n_phase = r_phase;
                        end
                        default: n_phase = r_phase;
                    endcase
                end
                OP_ROTATE: begin
                    if (r_phase != PH_IDLE) begin
                        n_reply = RP_BUSY;
                    end else begin
                        n_hold_len = (i_hold_value_ms != '0) ? i_hold_value_ms
                                                              : i_cfg.default_hold_ms;
                        n_move_dur = i_cfg.full_sweep_ms;
                        n_move_el  = '0;
                        n_phase    = PH_OUT;
                        n_dir      = i_cfg.forward_is_high;
                        n_run      = 1'b1;
                    end
                end
                OP_ZERO: begin
                    // Reverse for the time travelled out, else a full return leg unless already returning
                    priority if (r_phase == PH_OUT) begin
                        n_move_dur = w_el_min;
                        n_move_el  = '0;
                        n_phase    = PH_BACK;
                        n_dir      = !i_cfg.forward_is_high;
                        n_run      = 1'b1;
                    end else if (r_phase != PH_BACK) begin
                        n_move_dur = i_cfg.full_sweep_ms;
                        n_move_el  = '0;
                        n_phase    = PH_BACK;
                        n_dir      = !i_cfg.forward_is_high;
                        n_run      = 1'b1;
                    end else begin
                        n_phase = r_phase;
                    end
                end
                OP_SET_HOLD: begin
                    if (i_hold_value_ms == '0) begin
                        n_reply = RP_HOLD_ZERO;
                    end else begin
                        n_hold_len = i_hold_value_ms;
                    end
                end
                default: n_reply = RP_OK;
            endcase
        end else if (i_cmd.publish && w_moving) begin
            // Store the interpolated angle of a sweep in progress
            n_angle = w_interp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_move_el  <= '0;
            r_move_dur <= '0;
            r_hold_el  <= '0;
            r_hold_len <= RST_DEF_HOLD;
            r_angle    <= RST_HOME;
            r_dir      <= 1'b0;
            r_run      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_move_el  <= n_move_el;
            r_move_dur <= n_move_dur;
            r_hold_el  <= n_hold_el;
            r_hold_len <= n_hold_len;
            r_angle    <= n_angle;
            r_dir      <= n_dir;
            r_run      <= n_run;
        end
    end

    // Reply, product, divider and output registers carry payload only
    always_ff @(posedge i_clk) begin
        r_reply <= n_reply;
        if (i_cmd.mul) begin
            r_prod <= PROD_BITS'(w_mag) * PROD_BITS'(w_el_min);
            r_neg  <= w_neg;
        end
        if (i_cmd.div_init) begin
            r_rem <= r_prod[PROD_BITS-1:ANG_BITS];
            r_quo <= r_prod[ANG_BITS-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? TIME_BITS'(w_trial - {1'b0, r_move_dur}) : w_trial[TIME_BITS-1:0];
            r_quo <= {r_quo[ANG_BITS-2:0], w_ge};
        end
        if (i_cmd.publish) begin
            r_o_reply  <= r_reply;
            r_o_phase  <= r_phase;
            r_o_angle  <= w_moving ? w_interp : r_angle;
            r_o_remain <= w_remain;
            r_o_dir    <= r_dir;
            r_o_duty   <= r_run ? duty_scale(w_pct) : '0;
        end
    end

    assign o_reply_code        = r_o_reply;
    assign o_phase             = r_o_phase;
    assign o_estimated_angle   = r_o_angle;
    assign o_remaining_hold_ms = r_o_remain;
    assign o_direction_level   = r_o_dir;
    assign o_pwm_duty          = r_o_duty;

    a_run_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run == ((r_phase == PH_OUT) || (r_phase == PH_BACK)))
        else $error("motor run flag disagrees with arm phase");

    a_rem_below_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && r_move_dur != '0) |-> (r_rem < r_move_dur))
        else $error("divider remainder not below sweep duration");

endmodule

// ----- src/timed_sweep_hold_return_controller.sv -----
// Top level of the timed sweep, hold and return arm controller.
//
//  Channel  Direction  Handshake        Payload
//  i_in     in         valid / ready    opcode, hold_value_ms
//  o_out    out        valid / ready    reply_code, phase, estimated_angle,
//                                       remaining_hold_ms, direction_level, pwm_duty
//  i_cfg    in         i_cfg_we only    i_cfg_idx, i_cfg_data
//
// A beat passes from the accept state through the multiply state, the divider load
// state, ten restoring divide steps (one quotient bit each, set by the angle width)
// and the done state, which loads the output register; a new beat waits for idle.
// Synchronous active-low reset returns the arm to idle at home with the motor off
// and loads the register reset values.
// The output register holds a beat until taken; a new input beat is accepted
// while it waits, and the next result waits in the done state until it drains.
module timed_sweep_hold_return_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tshr_in_if.sink                             i_in,
    tshr_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [tshr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [tshr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import tshr_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;

    tshr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tshr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    tshr_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_cfg               (w_cfg),
        .i_opcode            (i_in.opcode),
        .i_hold_value_ms     (i_in.hold_value_ms),
        .o_reply_code        (o_out.reply_code),
        .o_phase             (o_out.phase),
        .o_estimated_angle   (o_out.estimated_angle),
        .o_remaining_hold_ms (o_out.remaining_hold_ms),
        .o_direction_level   (o_out.direction_level),
        .o_pwm_duty          (o_out.pwm_duty)
    );

endmodule

// ----- tb/timed_sweep_hold_return_controller_tb.sv -----
// Self-checking testbench of the timed sweep, hold and return controller: random beats against a predictor.
module timed_sweep_hold_return_controller_tb;
    import tshr_pkg::*;

    localparam int BEAT_CYCLES    = 14;
    localparam int SETTLE_CYCLES  = 2 * BEAT_CYCLES;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_WAIT       = 11;
    localparam int SHORT_SWEEP    = 12;
    localparam int SHORT_HOLD     = 10;

    typedef struct {
        t_op                  op;
        logic [TIME_BITS-1:0] val;
    } t_cmd_beat;

    typedef struct {
        t_reply                     reply;
        t_phase                     phase;
        logic signed [ANG_BITS-1:0] angle;
        logic [TIME_BITS-1:0]       remain;
        logic                       dir;
        logic [DUTY_BITS-1:0]       duty;
    } t_status_beat;

    logic i_clk;
    logic i_rst_n;

    logic                     drv_vld;
    logic [OP_BITS-1:0]       drv_op;
    logic [TIME_BITS-1:0]     drv_val;
    logic                     drv_rdy;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_idx;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    tshr_in_if  in_ch ();
    tshr_out_if out_ch ();

    assign in_ch.valid         = drv_vld;
    assign in_ch.opcode        = drv_op;
    assign in_ch.hold_value_ms = drv_val;
    assign out_ch.ready        = drv_rdy;

    timed_sweep_hold_return_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Register copies seen by the predictor
    logic [TIME_BITS-1:0]       cfg_sweep;
    logic signed [ANG_BITS-1:0] cfg_home;
    logic signed [ANG_BITS-1:0] cfg_target;
    logic [TIME_BITS-1:0]       cfg_hold;
    logic [PCT_BITS-1:0]        cfg_duty;
    logic                       cfg_fwd;

    // Arm state of the predictor
    t_phase                     arm_phase;
    logic [TIME_BITS-1:0]       mv_el;
    logic [TIME_BITS-1:0]       mv_len;
    logic [TIME_BITS-1:0]       hd_el;
    logic [TIME_BITS-1:0]       hd_len;
    logic signed [ANG_BITS-1:0] arm_ang;
    logic                       arm_dir;
    logic                       arm_run;

    t_cmd_beat    pend_q[$];
    t_status_beat status_q[$];

    int in_beats;
    int in_seen;
    int out_beats;
    int out_seen;
    int gap_left;
    int stall_left;
    int quiet_cycles;
    int mismatch_cnt;
    int queued;
    int eff_sweep;
    int eff_hold;
    logic drain_req;
    logic burst_in;
    logic burst_out;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [TIME_BITS-1:0] sat_up(input logic [TIME_BITS-1:0] v);
        return (v == TIME_MAX) ? v : v + 1'b1;
    endfunction

    // Interpolate the angle over the elapsed part of the current leg
    function automatic void track_angle();
        longint from_a;
        longint to_a;
        longint span;
        longint q;
        if (arm_phase != PH_OUT && arm_phase != PH_BACK) return;
        from_a = (arm_phase == PH_OUT) ? longint'(cfg_home) : longint'(cfg_target);
        to_a   = (arm_phase == PH_OUT) ? longint'(cfg_target) : longint'(cfg_home);
        if (mv_len == '0) begin
            arm_ang = ANG_BITS'(to_a);
            return;
        end
        span    = (mv_el >= mv_len) ? longint'(mv_len) : longint'(mv_el);
        q       = ((to_a - from_a) * span) / longint'(mv_len);
        arm_ang = ANG_BITS'(from_a + q);
    endfunction

    function automatic void motor_on(input logic fwd);
        arm_dir = fwd ? cfg_fwd : ~cfg_fwd;
        arm_run = 1'b1;
    endfunction

    function automatic void return_arm(input logic [TIME_BITS-1:0] ms);
        mv_len    = ms;
        mv_el     = '0;
        arm_phase = PH_BACK;
        motor_on(1'b0);
    endfunction

    // Head home: shortened leg when aborting the outward sweep, none when already returning
    function automatic void home_arm();
        if (arm_phase == PH_BACK) return;
        if (arm_phase == PH_OUT) begin
            return_arm((mv_el < mv_len) ? mv_el : mv_len);
        end else begin
            return_arm(cfg_sweep);
        end
    endfunction

    function automatic void tick_arm();
        case (arm_phase)
            PH_OUT: begin
                mv_el = sat_up(mv_el);
                track_angle();
                if (mv_el >= mv_len) begin
                    arm_ang   = cfg_target;
                    arm_run   = 1'b0;
                    arm_phase = PH_HOLD;
                    hd_el     = '0;
                end
            end
            PH_HOLD: begin
                hd_el = sat_up(hd_el);
                if (hd_el >= hd_len) home_arm();
            end
            PH_BACK: begin
                mv_el = sat_up(mv_el);
                track_angle();
                if (mv_el >= mv_len) begin
                    arm_ang   = cfg_home;
                    arm_run   = 1'b0;
                    arm_phase = PH_IDLE;
                    hd_len    = cfg_hold;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_status_beat predict_status(input t_cmd_beat c);
        t_status_beat        s;
        logic [PCT_BITS-1:0] pct;
        s.reply = RP_OK;
        case (c.op)
            OP_TICK: tick_arm();
            OP_ROTATE: begin
                if (arm_phase != PH_IDLE) begin
                    s.reply = RP_BUSY;
                end else begin
                    hd_len    = (c.val != '0) ? c.val : cfg_hold;
                    mv_len    = cfg_sweep;
                    mv_el     = '0;
                    arm_phase = PH_OUT;
                    motor_on(1'b1);
                end
            end
            OP_ZERO: home_arm();
            default: begin
                if (c.val == '0) s.reply = RP_HOLD_ZERO;
                else hd_len = c.val;
            end
        endcase
        track_angle();
        s.phase  = arm_phase;
        s.angle  = arm_ang;
        s.remain = (arm_phase == PH_HOLD && hd_el < hd_len) ? hd_len - hd_el : '0;
        s.dir    = arm_dir;
        pct      = (cfg_duty > PCT_FULL) ? PCT_FULL : cfg_duty;
        s.duty   = arm_run ? DUTY_BITS'((DUTY_MAX * longint'(pct)) / longint'(PCT_FULL)) : '0;
        return s;
    endfunction

    // ---------------- checking ----------------

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // Compare status beats, then predict for the command beat taken at this edge
    always @(posedge i_clk) begin : monitor
        t_status_beat want;
        t_cmd_beat    got_cmd;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                out_beats++;
                if (status_q.size() == 0) begin
                    $error("status beat with no expected beat waiting");
                    mismatch_cnt++;
                end else begin
                    want = status_q.pop_front();
                    check_field("reply_code", want.reply, out_ch.reply_code);
                    check_field("phase", want.phase, out_ch.phase);
                    check_field("estimated_angle", want.angle, out_ch.estimated_angle);
                    check_field("remaining_hold_ms", want.remain, out_ch.remaining_hold_ms);
                    check_field("direction_level", want.dir, out_ch.direction_level);
                    check_field("pwm_duty", want.duty, out_ch.pwm_duty);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                in_beats++;
                got_cmd.op  = t_op'(in_ch.opcode);
                got_cmd.val = in_ch.hold_value_ms;
                status_q.push_back(predict_status(got_cmd));
            end
        end
    end

    // Drop the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- driving ----------------

    // Command side: pop pending beats, insert gaps, pause now and then until drained
    always @(negedge i_clk) begin : drive_cmd
        t_cmd_beat            cur;
        logic                 nxt_vld;
        logic [OP_BITS-1:0]   nxt_op;
        logic [TIME_BITS-1:0] nxt_val;
        nxt_vld = drv_vld;
        nxt_op  = drv_op;
        nxt_val = drv_val;
        if (!i_rst_n) begin
            nxt_vld = 1'b0;
        end else begin
            if (drv_vld && in_beats != in_seen) begin
                in_seen = in_beats;
                nxt_vld = 1'b0;
                if ($urandom_range(0, 31) == 0) burst_in = ~burst_in;
                gap_left = burst_in ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 39) == 0) drain_req = 1'b1;
            end
            if (!nxt_vld) begin
                if (drain_req && status_q.size() == 0) drain_req = 1'b0;
                nxt_op  = OP_BITS'($urandom);
                nxt_val = TIME_BITS'($urandom);
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!drain_req && pend_q.size() != 0) begin
                    cur     = pend_q.pop_front();
                    nxt_op  = cur.op;
                    nxt_val = cur.val;
                    nxt_vld = 1'b1;
                end
            end
        end
        drv_vld <= nxt_vld;
        drv_op  <= nxt_op;
        drv_val <= nxt_val;
    end

    // Status side: hold ready low for a drawn stall once a beat is offered
    always @(negedge i_clk) begin : drive_status
        logic nxt_rdy;
        nxt_rdy = drv_rdy;
        if (!i_rst_n) begin
            nxt_rdy = 1'b0;
        end else begin
            if (out_beats != out_seen) begin
                out_seen = out_beats;
                if ($urandom_range(0, 31) == 0) burst_out = ~burst_out;
                stall_left = burst_out ? 0 : $urandom_range(0, MAX_WAIT);
                nxt_rdy    = burst_out;
            end
            if (!nxt_rdy && out_ch.valid) begin
                if (stall_left != 0) stall_left--;
                else nxt_rdy = 1'b1;
            end else if (!nxt_rdy && !burst_out && stall_left == 0) begin
                nxt_rdy = 1'b1;
            end
        end
        drv_rdy <= nxt_rdy;
    end

    // ---------------- stimulus ----------------

    task automatic queue_beat(input t_op op, input logic [TIME_BITS-1:0] v);
        t_cmd_beat b;
        b.op  = op;
        b.val = v;
        pend_q.push_back(b);
        queued++;
    endtask

    function automatic logic [TIME_BITS-1:0] pick_hold();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return '0;
        if (r < 8) return TIME_BITS'($urandom_range(1, eff_hold));
        if (r == 8) return TIME_BITS'($urandom);
        return TIME_MAX;
    endfunction

    // Rotate, then mostly ticks with random commands mixed in
    task automatic queue_episode();
        int ticks;
        int r;
        queue_beat(OP_ROTATE, pick_hold());
        ticks = $urandom_range(1, 2 * eff_sweep + eff_hold + 3);
        repeat (ticks) begin
            r = $urandom_range(0, 99);
            if (r < 86) queue_beat(OP_TICK, TIME_BITS'($urandom));
            else if (r < 91) queue_beat(OP_ZERO, TIME_BITS'($urandom));
            else if (r < 96) queue_beat(OP_SET_HOLD, pick_hold());
            else queue_beat(OP_ROTATE, pick_hold());
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_FULL_SWEEP: cfg_sweep  = data;
            CFG_HOME:       cfg_home   = data[ANG_BITS-1:0];
            CFG_TARGET:     cfg_target = data[ANG_BITS-1:0];
            CFG_DEF_HOLD:   cfg_hold   = data;
            CFG_DUTY:       cfg_duty   = data[PCT_BITS-1:0];
            CFG_FWD_HIGH:   cfg_fwd    = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup_arm(input int sweep, input int home, input int target, input int hold,
                             input int duty, input int fwd);
        write_reg(CFG_FULL_SWEEP, CFG_DATA_BITS'(sweep));
        write_reg(CFG_HOME, CFG_DATA_BITS'(home));
        write_reg(CFG_TARGET, CFG_DATA_BITS'(target));
        write_reg(CFG_DEF_HOLD, CFG_DATA_BITS'(hold));
        write_reg(CFG_DUTY, CFG_DATA_BITS'(duty));
        write_reg(CFG_FWD_HIGH, CFG_DATA_BITS'(fwd));
        eff_sweep = (sweep > SHORT_SWEEP) ? SHORT_SWEEP : sweep;
        eff_hold  = (hold > SHORT_HOLD) ? SHORT_HOLD : hold;
    endtask

    // Hold until every beat is sent and answered, then let the block settle
    task automatic wait_drained();
        while (pend_q.size() != 0 || drv_vld || status_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : run_phases
        int k;
        int phase_len;
        drv_vld      = 1'b0;
        drv_op       = OP_TICK;
        drv_val      = '0;
        drv_rdy      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_FULL_SWEEP;
        cfg_data     = '0;
        in_beats     = 0;
        in_seen      = 0;
        out_beats    = 0;
        out_seen     = 0;
        gap_left     = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        mismatch_cnt = 0;
        queued       = 0;
        drain_req    = 1'b0;
        burst_in     = 1'b0;
        burst_out    = 1'b0;
        eff_sweep    = SHORT_SWEEP;
        eff_hold     = SHORT_HOLD;

        // Predictor starts from the register and arm reset state
        cfg_sweep  = RST_FULL_SWEEP;
        cfg_home   = RST_HOME;
        cfg_target = RST_TARGET;
        cfg_hold   = RST_DEF_HOLD;
        cfg_duty   = RST_DUTY;
        cfg_fwd    = RST_FWD_HIGH;
        arm_phase  = PH_IDLE;
        mv_el      = '0;
        mv_len     = '0;
        hd_el      = '0;
        hd_len     = RST_DEF_HOLD;
        arm_ang    = RST_HOME;
        arm_dir    = 1'b0;
        arm_run    = 1'b0;

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: default hold, refused commands, abort of the outward sweep
        queue_beat(OP_TICK, '0);
        queue_beat(OP_ROTATE, '0);
        queue_beat(OP_TICK, TIME_MAX);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_SET_HOLD, '0);
        queue_beat(OP_ROTATE, TIME_BITS'(7));
        queue_beat(OP_SET_HOLD, TIME_BITS'(7));
        queue_beat(OP_ZERO, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        wait_drained();

        // Extreme angles, duty above full scale, reversed direction sense
        setup_arm(3, -360, 360, 2, 127, 0);
        queue_beat(OP_ZERO, TIME_MAX);
        queue_beat(OP_ZERO, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_ROTATE, TIME_MAX);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_SET_HOLD, TIME_BITS'(1));
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        queue_beat(OP_TICK, '0);
        wait_drained();

        // Random phases, each under its own register setting
        for (k = 0; k < 8; k++) begin
            case (k)
                0: setup_arm($urandom_range(1, 8), -360, 360, 1, 0, 0);
                1: setup_arm(0, 360, -360, $urandom_range(1, 6), 100, 1);
                2: setup_arm(int'(TIME_MAX), int'($urandom_range(0, 720)) - 360,
                             int'($urandom_range(0, 720)) - 360, int'(TIME_MAX),
                             $urandom_range(0, 100), $urandom_range(0, 1));
                default: setup_arm($urandom_range(1, SHORT_SWEEP),
                                   int'($urandom_range(0, 720)) - 360,
                                   int'($urandom_range(0, 720)) - 360,
                                   $urandom_range(1, SHORT_HOLD),
                                   ($urandom_range(0, 7) == 0) ? $urandom_range(101, 127)
                                                               : $urandom_range(0, 100),
                                   $urandom_range(0, 1));
            endcase
            phase_len = (k == 2) ? 20 : 54;
            queued = 0;
            while (queued < phase_len) queue_episode();
            wait_drained();
        end

        repeat (BEAT_CYCLES) @(negedge i_clk);
        if (mismatch_cnt == 0 && status_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
